/* rtl/assert_macros.svh */
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("assertion failed");
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error("implication failed");
`else
`define ASSERT_CLK(label, prop)
`define ASSERT_IMPL(label, ante, cons)
`endif
`endif

/* rtl/tqs_pkg.sv */
// types and constants of the timer queue scheduler
package tqs_pkg;
  localparam logic [1:0] CMD_ADD    = 2'd0;
  localparam logic [1:0] CMD_CANCEL = 2'd1;
  localparam logic [1:0] CMD_TICK   = 2'd2;
  localparam logic [1:0] CMD_NOP    = 2'd3;
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;
  localparam logic       KIND_REPORT = 1'b0;
  localparam logic       KIND_CLOSE  = 1'b1;
  localparam logic [62:0] TIME_MAX = {63{1'b1}};
  localparam logic [19:0] MIN_REARM_RESET = 20'd100;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] timer_id;
    logic [62:0] expire_time;
    logic [39:0] interval_us;
    logic [62:0] now_us;
  } in_word_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] fired_id;
    logic [1:0]  status;
    logic        earliest_changed;
    logic        pending_valid;
    logic [62:0] rearm_delay_us;
    logic        last;
  } out_word_t;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture input word
    logic scan_clr;  // start a scan
    logic scan_step; // examine one slot
    logic sel_due;   // scan picks best due, not done
    logic mark_done; // mark the scan winner done
    logic write_add; // store the added timer
    logic cancel_st; // apply cancel on current slot
    logic rearm_st;  // rearm or free current slot
    logic emit_rep;  // produce report word
    logic emit_cls;  // produce closing word
  } tqs_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_end;
    logic best_found;
    logic out_busy;
  } tqs_sts_t;
endpackage

/* rtl/tqs_ctrl.sv */
// controller of the timer queue scheduler
module tqs_ctrl import tqs_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] cmd,
  input  tqs_sts_t   sts,
  output tqs_cmd_t   ctl
);
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PRE   = 3'd1; // scan for earliest / free / cancel / due
  localparam logic [2:0] S_DUE   = 3'd2; // scan for next due
  localparam logic [2:0] S_REP   = 3'd3;
  localparam logic [2:0] S_REARM = 3'd4;
  localparam logic [2:0] S_FIN   = 3'd5; // scan for earliest after change
  localparam logic [2:0] S_CLS   = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic [1:0] cmd_r;

  assign in_ready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cmd_r <= CMD_ADD;
    end else begin
      state_r <= state_nxt;
      if (in_valid && in_ready) cmd_r <= cmd;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ctl = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          ctl.load = 1'b1;
          ctl.scan_clr = 1'b1;
          state_nxt = S_PRE;
        end
      end
      S_PRE: begin
        ctl.scan_step = 1'b1;
        ctl.cancel_st = (cmd_r == CMD_CANCEL);
        if (sts.scan_end) begin
          ctl.write_add = (cmd_r == CMD_ADD);
          ctl.scan_clr = 1'b1;
          state_nxt = (cmd_r == CMD_TICK) ? S_DUE : S_FIN;
        end
      end
      S_DUE: begin
        ctl.scan_step = 1'b1;
        ctl.sel_due = 1'b1;
        if (sts.scan_end) begin
          ctl.scan_clr = 1'b1;
          state_nxt = sts.best_found ? S_REP : S_REARM;
        end
      end
      S_REP: begin
        if (!sts.out_busy) begin
          ctl.emit_rep = 1'b1;
          ctl.mark_done = 1'b1;
          state_nxt = S_DUE;
        end
      end
      S_REARM: begin
        ctl.scan_step = 1'b1;
        ctl.rearm_st = 1'b1;
        if (sts.scan_end) begin
          ctl.scan_clr = 1'b1;
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        ctl.scan_step = 1'b1;
        if (sts.scan_end) state_nxt = S_CLS;
      end
      S_CLS: begin
        if (!sts.out_busy) begin
          ctl.emit_cls = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  `include "assert_macros.svh"
  `ASSERT_IMPL(a_ready_idle, in_ready, state_r == S_IDLE)
  `ASSERT_IMPL(a_emit_excl, ctl.emit_rep, !ctl.emit_cls)
  `ASSERT_CLK(a_cls_to_idle, ctl.emit_cls |=> state_r == S_IDLE)
endmodule

/* rtl/tqs_dp.sv */
// datapath of the timer queue scheduler: slot table, scan unit, output register
module tqs_dp import tqs_pkg::*; #(
  parameter int SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [19:0] cfg_wdata,
  input  in_word_t    in_word,
  input  tqs_cmd_t    ctl,
  output tqs_sts_t    sts,
  output logic        out_valid,
  input  logic        out_ready,
  output out_word_t   out_word
);
  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  logic [19:0] min_rearm_r;
  in_word_t    req_r;
  logic [SLOTS-1:0] used_r, due_r, done_r;
  logic [31:0] id_mem [SLOTS];
  logic [62:0] exp_mem [SLOTS];
  logic [39:0] ivl_mem [SLOTS];

  logic [IW:0]   idx_r;
  logic [IW-1:0] cur;
  logic          best_v_r, free_v_r, found_r, chg_r;
  logic [IW-1:0] best_i_r, free_i_r;
  logic [62:0]   best_e_r;
  logic [31:0]   best_id_r;
  logic          out_valid_r;
  out_word_t     out_r;

  logic        cand, better;
  logic [63:0] sum;
  logic [62:0] lead;

  assign cur = idx_r[IW-1:0];
  assign sts.scan_end = (idx_r == (IW+1)'(SLOTS - 1));
  assign sts.best_found = best_v_r || cand;
  assign sts.out_busy = out_valid_r && !out_ready;
  assign out_valid = out_valid_r;
  assign out_word = out_r;

  always_comb begin
    if (ctl.sel_due) cand = due_r[cur] && !done_r[cur];
    else cand = used_r[cur];
    better = !best_v_r || (exp_mem[cur] < best_e_r) ||
             ((exp_mem[cur] == best_e_r) && (id_mem[cur] < best_id_r));
    sum = {1'b0, req_r.now_us} + {24'd0, ivl_mem[cur]};
    lead = (best_e_r > req_r.now_us) ? (best_e_r - req_r.now_us) : 63'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_rearm_r <= MIN_REARM_RESET;
      used_r <= '0;
      due_r <= '0;
      done_r <= '0;
      out_valid_r <= 1'b0;
      idx_r <= '0;
      best_v_r <= 1'b0;
    end else begin
      if (cfg_we) min_rearm_r <= cfg_wdata;
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      if (ctl.load) begin
        req_r <= in_word;
        free_v_r <= 1'b0;
        found_r <= 1'b0;
        chg_r <= 1'b0;
        due_r <= '0;
        done_r <= '0;
      end
      if (ctl.scan_step) begin
        idx_r <= idx_r + 1'b1;
        if (cand && better) begin
          best_v_r <= 1'b1;
          best_i_r <= cur;
          best_e_r <= exp_mem[cur];
          best_id_r <= id_mem[cur];
        end
        if (!ctl.sel_due && !ctl.rearm_st) begin
          if (!used_r[cur] && !free_v_r) begin
            free_v_r <= 1'b1;
            free_i_r <= cur;
          end
          if (req_r.command == CMD_TICK && !done_r[cur])
            due_r[cur] <= used_r[cur] && (exp_mem[cur] <= req_r.now_us);
        end
        if (ctl.cancel_st && used_r[cur] && id_mem[cur] == req_r.timer_id) begin
          used_r[cur] <= 1'b0;
          found_r <= 1'b1;
        end
        if (ctl.rearm_st && due_r[cur]) begin
          if (ivl_mem[cur] != 40'd0) exp_mem[cur] <= sum[63] ? TIME_MAX : sum[62:0];
          else used_r[cur] <= 1'b0;
        end
      end
      if (ctl.write_add) begin
        if (free_v_r || !used_r[cur]) begin
          used_r[free_v_r ? free_i_r : cur] <= 1'b1;
          id_mem[free_v_r ? free_i_r : cur] <= req_r.timer_id;
          exp_mem[free_v_r ? free_i_r : cur] <= req_r.expire_time;
          ivl_mem[free_v_r ? free_i_r : cur] <= req_r.interval_us;
          chg_r <= !(best_v_r || (cand && better)) ||
                   (req_r.expire_time < ((cand && better) ? exp_mem[cur] : best_e_r));
        end else begin
          found_r <= 1'b1; // reused as full flag on add
        end
      end
      if (ctl.mark_done) done_r[best_i_r] <= 1'b1;
      if (ctl.scan_clr) begin
        idx_r <= '0;
        best_v_r <= 1'b0;
      end
      if (ctl.emit_rep) begin
        out_valid_r <= 1'b1;
        out_r <= '{kind: KIND_REPORT, fired_id: best_id_r, status: ST_OK,
                   earliest_changed: 1'b0, pending_valid: 1'b0,
                   rearm_delay_us: 63'd0, last: 1'b0};
        best_v_r <= 1'b0;
      end
      if (ctl.emit_cls) begin
        out_valid_r <= 1'b1;
        out_r.kind <= KIND_CLOSE;
        out_r.fired_id <= 32'd0;
        out_r.last <= 1'b1;
        out_r.pending_valid <= best_v_r;
        out_r.rearm_delay_us <= !best_v_r ? 63'd0 :
          (lead < {43'd0, min_rearm_r}) ? {43'd0, min_rearm_r} : lead;
        out_r.earliest_changed <= (req_r.command == CMD_ADD) && chg_r;
        if (req_r.command == CMD_ADD && found_r) out_r.status <= ST_FULL;
        else if (req_r.command == CMD_CANCEL && !found_r) out_r.status <= ST_NOTFOUND;
        else out_r.status <= ST_OK;
      end
    end
  end

  `include "assert_macros.svh"
  `ASSERT_IMPL(a_no_overwrite, out_valid_r && !out_ready, !ctl.emit_rep && !ctl.emit_cls)
  `ASSERT_IMPL(a_done_subset, 1'b1, (done_r & ~due_r) == '0)
  `ASSERT_IMPL(a_idx_range, ctl.scan_step, idx_r < (IW+1)'(SLOTS))
endmodule

/* rtl/timer_queue_scheduler_unit.sv */
// top level of the timer queue scheduler
//  channel | direction | handshake
//  in_     | input     | in_valid / in_ready, in_word
//  out_    | output    | out_valid / out_ready, out_word
//  cfg_    | input     | cfg_we / cfg_wdata, no wait
// add/cancel: a slot scan, then a scan for the earliest timer, then the closing word
// tick: a slot scan marks due slots, then a due scan and a report per fired timer,
// one more due scan, then a rearm scan and an earliest scan, then the closing word;
// the single slot scan unit sets the pace
// reset clears all slot valid bits at once, no clearing pass
// a stalled output holds the controller in its emit state
module timer_queue_scheduler_unit import tqs_pkg::*; #(
  parameter int SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_word_t    in_word,
  output logic        out_valid,
  input  logic        out_ready,
  output out_word_t   out_word,
  input  logic        cfg_we,
  input  logic [19:0] cfg_wdata
);
  tqs_cmd_t ctl;
  tqs_sts_t sts;

  tqs_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .cmd(in_word.command), .sts(sts), .ctl(ctl)
  );

  tqs_dp #(.SLOTS(SLOTS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_word(in_word), .ctl(ctl), .sts(sts), .out_valid(out_valid),
    .out_ready(out_ready), .out_word(out_word)
  );
endmodule

/* test/timer_queue_scheduler_unit_tb.sv */
// testbench for the timer queue scheduler: directed and random traffic checked against a behavioural model
`timescale 1ns / 1ps

module timer_queue_scheduler_unit_tb;
  import tqs_pkg::*;

  localparam int NSLOT = 16;
  localparam int DOG_LIMIT = 5000;

  typedef struct {
    in_word_t w;
    bit       drain;
  } job_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_word_t    in_word = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_word_t   out_word;
  logic        cfg_we = 1'b0;
  logic [19:0] cfg_wdata = '0;

  job_t      job_q[$];
  job_t      nxt_job;
  out_word_t due_q[$];

  // model of the timer table
  bit          t_used[NSLOT];
  logic [31:0] t_id[NSLOT];
  logic [62:0] t_exp[NSLOT];
  logic [39:0] t_ivl[NSLOT];
  logic [19:0] rearm_floor = MIN_REARM_RESET;

  logic [62:0] vclock = '0;
  int gap_cnt = 0, stall_cnt = 0, dog = 0;
  int errors = 0, n_words = 0, n_results = 0, n_fired = 0, n_full = 0;
  bit burst_in = 0, burst_out = 0;

  timer_queue_scheduler_unit u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_word(in_word),
    .out_valid(out_valid), .out_ready(out_ready), .out_word(out_word),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int earliest_timer();
    int best;
    best = -1;
    for (int i = 0; i < NSLOT; i++) begin
      if (t_used[i] && (best < 0 || t_exp[i] < t_exp[best] ||
          (t_exp[i] == t_exp[best] && t_id[i] < t_id[best]))) best = i;
    end
    return best;
  endfunction

  task automatic schedule_timers(input in_word_t w);
    out_word_t r;
    bit due[NSLOT];
    bit done[NSLOT];
    int e, slot, best;
    bit found;
    logic [63:0] sum;
    logic [62:0] lead;
    r = '0;
    r.kind = KIND_CLOSE;
    r.last = 1'b1;
    if (w.command == CMD_ADD) begin
      slot = -1;
      for (int i = NSLOT - 1; i >= 0; i--) if (!t_used[i]) slot = i;
      if (slot < 0) begin
        r.status = ST_FULL;
        n_full++;
      end else begin
        e = earliest_timer();
        r.earliest_changed = (e < 0 || w.expire_time < t_exp[e]);
        t_used[slot] = 1;
        t_id[slot] = w.timer_id;
        t_exp[slot] = w.expire_time;
        t_ivl[slot] = w.interval_us;
      end
    end else if (w.command == CMD_CANCEL) begin
      found = 0;
      for (int i = 0; i < NSLOT; i++) begin
        if (t_used[i] && t_id[i] == w.timer_id) begin
          t_used[i] = 0;
          found = 1;
        end
      end
      if (!found) r.status = ST_NOTFOUND;
    end else if (w.command == CMD_TICK) begin
      for (int i = 0; i < NSLOT; i++) begin
        due[i] = t_used[i] && t_exp[i] <= w.now_us;
        done[i] = 0;
      end
      forever begin
        best = -1;
        for (int i = 0; i < NSLOT; i++) begin
          if (due[i] && !done[i] && (best < 0 || t_exp[i] < t_exp[best] ||
              (t_exp[i] == t_exp[best] && t_id[i] < t_id[best]))) best = i;
        end
        if (best < 0) break;
        done[best] = 1;
        due_q.push_back('{kind: KIND_REPORT, fired_id: t_id[best], default: '0});
        n_fired++;
      end
      for (int i = 0; i < NSLOT; i++) begin
        if (due[i]) begin
          if (t_ivl[i] != 0) begin
            sum = {1'b0, w.now_us} + {24'd0, t_ivl[i]};
            t_exp[i] = sum[63] ? TIME_MAX : sum[62:0];
          end else begin
            t_used[i] = 0;
          end
        end
      end
    end
    e = earliest_timer();
    if (e >= 0) begin
      lead = t_exp[e] > w.now_us ? t_exp[e] - w.now_us : '0;
      r.pending_valid = 1'b1;
      r.rearm_delay_us = lead < {43'd0, rearm_floor} ? {43'd0, rearm_floor} : lead;
    end
    due_q.push_back(r);
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        schedule_timers(in_word);
        n_words++;
      end
      if (!in_valid || in_ready) begin
        if (job_q.size() != 0 && job_q[0].drain && due_q.size() != 0) begin
          in_valid <= 1'b0;
        end else if (gap_cnt > 0) begin
          gap_cnt <= gap_cnt - 1;
          in_valid <= 1'b0;
        end else if (job_q.size() != 0) begin
          nxt_job = job_q.pop_front();
          in_word <= nxt_job.w;
          in_valid <= 1'b1;
          if ($urandom_range(0, 19) == 0) burst_in = !burst_in;
          gap_cnt <= burst_in ? 0 : $urandom_range(0, 9);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (out_valid && out_ready) begin
      n_results++;
      if (due_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected word %h", out_word);
      end else begin
        out_word_t x;
        x = due_q.pop_front();
        if (out_word.kind !== x.kind || out_word.fired_id !== x.fired_id ||
            out_word.status !== x.status || out_word.earliest_changed !== x.earliest_changed ||
            out_word.pending_valid !== x.pending_valid ||
            out_word.rearm_delay_us !== x.rearm_delay_us || out_word.last !== x.last) begin
          errors++;
          if (errors <= 10) $display("mismatch: expected %p actual %p", x, out_word);
        end
      end
      if ($urandom_range(0, 19) == 0) burst_out = !burst_out;
      stall_cnt = burst_out ? 0 : $urandom_range(0, 9);
      out_ready <= (stall_cnt == 0);
    end else if (!out_ready) begin
      if (stall_cnt <= 1) out_ready <= 1'b1;
      stall_cnt = stall_cnt - 1;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) dog <= 0;
    else dog <= dog + 1;
    if (dog >= DOG_LIMIT) begin
      $display("timer_queue_scheduler_unit_tb: errors");
      $finish;
    end
  end

  function automatic logic [62:0] wide63();
    return 63'({$urandom, $urandom});
  endfunction

  function automatic in_word_t mk(logic [1:0] c, logic [31:0] id, logic [62:0] ex,
                                  logic [39:0] iv, logic [62:0] nw);
    in_word_t w;
    w.command = c;
    w.timer_id = id;
    w.expire_time = ex;
    w.interval_us = iv;
    w.now_us = nw;
    return w;
  endfunction

  task automatic queue_word(input in_word_t w, input bit drain = 0);
    job_q.push_back('{w: w, drain: drain});
  endtask

  function automatic in_word_t random_word();
    int sel;
    logic [31:0] id;
    logic [62:0] ex;
    logic [39:0] iv;
    sel = $urandom_range(0, 99);
    id = ($urandom_range(0, 9) < 8) ? 32'($urandom_range(0, 23)) : $urandom;
    if ($urandom_range(0, 29) == 0) vclock = wide63();
    else vclock = vclock + $urandom_range(0, 1500);
    ex = ($urandom_range(0, 9) == 0) ? wide63() : vclock + $urandom_range(0, 5000);
    case ($urandom_range(0, 9))
      0: iv = 40'({$urandom, $urandom});
      1, 2, 3, 4: iv = 40'($urandom_range(1, 4000));
      default: iv = '0;
    endcase
    if (sel < 45) return mk(CMD_ADD, id, ex, iv, vclock);
    if (sel < 65) return mk(CMD_CANCEL, id, wide63(), 40'({$urandom, $urandom}), vclock);
    if (sel < 96) return mk(CMD_TICK, $urandom, wide63(), 40'({$urandom, $urandom}), vclock);
    return mk(CMD_NOP, $urandom, wide63(), 40'({$urandom, $urandom}), vclock);
  endfunction

  task automatic settle();
    while (job_q.size() != 0 || in_valid || due_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_floor(input logic [19:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    rearm_floor = v;
  endtask

  task automatic random_phase(input int n);
    for (int i = 0; i < 17; i++)
      queue_word(mk(CMD_ADD, 32'($urandom_range(0, 23)), vclock + $urandom_range(0, 900),
                    $urandom_range(0, 1) ? 40'd0 : 40'($urandom_range(1, 900)), vclock));
    for (int i = 0; i < n; i++) queue_word(random_word(), (i % 40) == 39);
    settle();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    queue_word(mk(CMD_TICK, '0, '0, '0, '0));
    queue_word(mk(CMD_CANCEL, 32'd77, '0, '0, 63'd10));
    queue_word(mk(CMD_ADD, 32'd0, 63'd1000, '0, 63'd10));
    queue_word(mk(CMD_ADD, 32'hFFFF_FFFF, 63'd1000, 40'd50, 63'd10));
    queue_word(mk(CMD_ADD, 32'd5, 63'd900, '0, 63'd10));
    queue_word(mk(CMD_ADD, 32'd5, 63'd900, 40'd7, 63'd10));
    queue_word(mk(CMD_ADD, 32'd9, TIME_MAX, 40'hFF_FFFF_FFFF, 63'd20));
    queue_word(mk(CMD_ADD, 32'd3, 63'd1000, '0, 63'd30));
    queue_word(mk(CMD_ADD, 32'd4, 63'd0, '0, 63'd30));
    queue_word(mk(CMD_TICK, '0, '0, '0, 63'd950));
    queue_word(mk(CMD_TICK, 32'hFFFF_FFFF, TIME_MAX, 40'hFF_FFFF_FFFF, 63'd1000), 1);
    queue_word(mk(CMD_NOP, 32'hFFFF_FFFF, TIME_MAX, 40'hFF_FFFF_FFFF, TIME_MAX));
    queue_word(mk(CMD_CANCEL, 32'd5, '0, '0, 63'd1000));
    queue_word(mk(CMD_CANCEL, 32'd5, '0, '0, 63'd1000));
    queue_word(mk(CMD_TICK, '0, '0, '0, TIME_MAX - 63'd3));
    queue_word(mk(CMD_TICK, '0, '0, '0, TIME_MAX));
    queue_word(mk(CMD_CANCEL, 32'd9, '0, '0, TIME_MAX));
    queue_word(mk(CMD_CANCEL, 32'hFFFF_FFFF, '0, '0, '0));
    queue_word(mk(CMD_CANCEL, 32'd3, '0, '0, '0));
    settle();
    write_floor(20'd0);
    random_phase(70);
    write_floor(20'hF_FFFF);
    random_phase(70);
    write_floor(20'($urandom_range(0, 4000)));
    random_phase(70);
    repeat (100) @(posedge clk);
    $display("%0d commands sent, %0d words checked, %0d timers fired, %0d adds into a full table",
             n_words, n_results, n_fired, n_full);
    $display("rearm floors used: 100, 0, 1048575 and one random value");
    if (errors == 0 && due_q.size() == 0) begin
      $display("timer_queue_scheduler_unit_tb: clean");
    end else begin
      $display("timer_queue_scheduler_unit_tb: errors");
    end
    $finish;
  end
endmodule
